// ----- rtl/rct_pkg.sv -----
// Shared types and constants for the range color table.
`timescale 1ns / 1ps
`default_nettype none
package rct_pkg;
	localparam int TableDepthDefault = 64;
	localparam int IdW = 16;
	localparam int ColorW = 24;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COUNT_RD,
		ST_COUNT_EV,
		ST_COPY_RD,
		ST_COPY_EV,
		ST_LOOK_RD,
		ST_LOOK_EV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [IdW-1:0]    lo;
		logic [IdW-1:0]    hi;
		logic [ColorW-1:0] color;
	} entry_t;
endpackage
`default_nettype wire

// ----- rtl/rct_mem.sv -----
// Simple dual-port entry memory (separate read and write addresses) with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rct_mem #(
	parameter int Depth = rct_pkg::TableDepthDefault,
	parameter int AddrW = $clog2(Depth)
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AddrW-1:0] waddr,
	input  wire rct_pkg::entry_t wdata,
	input  wire logic [AddrW-1:0] raddr,
	output rct_pkg::entry_t      rdata
);
	rct_pkg::entry_t mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- rtl/range_color_table_top.sv -----
// Top level of the range color table: sequencer, entry banks and result register.
`timescale 1ns / 1ps
`default_nettype none
// Range color table. Each beat on s_axis carries an opcode: insert a range
// with a color, look up an id, clear, or none. Exactly one result beat follows
// each input beat. A lookup scans the entries in order, a read and an evaluate
// state per entry, and stops at the first hit. An insert with low above high
// is ignored; otherwise it makes a counting pass over all entries to check for
// overflow, then, if the result fits, a rewrite pass that reads the table from
// one bank and writes the merged table into the other, one read state and
// three write sub-steps per entry. A clear only resets the entry count.
// The block takes a new beat only after the result has been delivered and
// stays ready for no other beat while it works. Memory needs no clearing.
module range_color_table_top #(
	parameter int TABLE_DEPTH = rct_pkg::TableDepthDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// opcode[1:0], range_low[17:2], range_high[33:18], red_in[41:34],
	// green_in[49:42], blue_in[57:50], region_id[73:58], zero pad to 80
	input  wire logic [79:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// hit[0], red_out[8:1], green_out[16:9], blue_out[24:17], status[25], pad to 32
	output logic [31:0]      m_axis_tdata
);
	localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CntW = $clog2(TABLE_DEPTH + 3) + 1;
	localparam logic [CntW-1:0] DepthC = CntW'(TABLE_DEPTH);

	rct_pkg::state_t state_q, state_d;
	logic [15:0] lo_q, hi_q, id_q;
	logic [23:0] col_q;
	logic        bank_q;
	logic [CntW-1:0] count_q, idx_q, n_q;
	logic        placed_q;
	logic [2:0]  sub_q;
	logic        hit_q, status_q;
	logic [23:0] rcol_q;
	logic        outv_q;

	rct_pkg::entry_t rd0, rd1, rd, wdata;
	logic        we0, we1, we;
	logic [AddrW-1:0] raddr, waddr;

	assign rd = bank_q ? rd1 : rd0;
	assign we0 = we & bank_q;
	assign we1 = we & ~bank_q;

	rct_mem #(.Depth(TABLE_DEPTH), .AddrW(AddrW)) u_bank0 (
		.clk(clk), .we(we0), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rd0)
	);
	rct_mem #(.Depth(TABLE_DEPTH), .AddrW(AddrW)) u_bank1 (
		.clk(clk), .we(we1), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rd1)
	);

	assign raddr = idx_q[AddrW-1:0];
	assign waddr = n_q[AddrW-1:0];

	// Per-entry classification against the new range.
	logic e_below, e_above, e_left, e_right;
	assign e_below = rd.hi < lo_q;
	assign e_above = rd.lo > hi_q;
	assign e_left  = rd.lo < lo_q;
	assign e_right = rd.hi > hi_q;

	// In the copy pass each entry emits up to three pieces in sub-steps.
	// sub 0: left/whole piece, sub 1: new range, sub 2: right/whole piece, sub 3: new range at the end.
	logic emit;
	always_comb begin
		emit = 1'b0;
		wdata = rd;
		case (sub_q)
			3'd0: begin
				if (e_below) begin
					emit = 1'b1;
				end else if (!e_above && e_left) begin
					emit = 1'b1;
					wdata.hi = lo_q - 16'd1;
				end
			end
			3'd1: begin
				emit = !e_below && !placed_q;
				wdata = '{lo: lo_q, hi: hi_q, color: col_q};
			end
			3'd2: begin
				if (e_above) begin
					emit = 1'b1;
				end else if (!e_below && e_right) begin
					emit = 1'b1;
					wdata.lo = hi_q + 16'd1;
				end
			end
			3'd3: begin
				emit = !placed_q;
				wdata = '{lo: lo_q, hi: hi_q, color: col_q};
			end
			default: emit = 1'b0;
		endcase
	end
	assign we = (state_q == rct_pkg::ST_COPY_EV) && emit;

	logic [1:0] cnt_add;
	assign cnt_add = (!e_below && !e_above && e_left ? 2'd1 : 2'd0)
		+ (!e_below && !e_above && e_right ? 2'd1 : 2'd0)
		+ ((e_below || e_above) ? 2'd1 : 2'd0);
	logic hit_e;
	assign hit_e = (id_q >= rd.lo) && (id_q <= rd.hi);

	logic in_acc;
	assign in_acc = s_axis_tvalid && s_axis_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			rct_pkg::ST_IDLE: begin
				if (in_acc) begin
					case (rct_pkg::opcode_t'(s_axis_tdata[1:0]))
						rct_pkg::OP_INSERT: state_d =
							(s_axis_tdata[17:2] > s_axis_tdata[33:18]) ?
							rct_pkg::ST_DONE : rct_pkg::ST_COUNT_RD;
						rct_pkg::OP_LOOKUP: state_d = rct_pkg::ST_LOOK_RD;
						default: state_d = rct_pkg::ST_DONE;
					endcase
				end
			end
			rct_pkg::ST_COUNT_RD: begin
				// n_q holds pieces of old entries; the new range adds one.
				if (idx_q != count_q) state_d = rct_pkg::ST_COUNT_EV;
				else if (n_q + CntW'(1) > DepthC) state_d = rct_pkg::ST_DONE;
				else if (count_q == '0) state_d = rct_pkg::ST_COPY_EV;
				else state_d = rct_pkg::ST_COPY_RD;
			end
			rct_pkg::ST_COUNT_EV: state_d = rct_pkg::ST_COUNT_RD;
			rct_pkg::ST_COPY_RD: state_d = rct_pkg::ST_COPY_EV;
			rct_pkg::ST_COPY_EV: begin
				if (sub_q == 3'd3) state_d = rct_pkg::ST_DONE;
				else if (sub_q == 3'd2 && idx_q + CntW'(1) != count_q)
					state_d = rct_pkg::ST_COPY_RD;
			end
			rct_pkg::ST_LOOK_RD: state_d = (idx_q == count_q) ?
				rct_pkg::ST_DONE : rct_pkg::ST_LOOK_EV;
			rct_pkg::ST_LOOK_EV: state_d = hit_e ? rct_pkg::ST_DONE :
				rct_pkg::ST_LOOK_RD;
			rct_pkg::ST_DONE: if (!outv_q) state_d = rct_pkg::ST_IDLE;
			default: state_d = rct_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == rct_pkg::ST_IDLE);
		m_axis_tvalid = outv_q;
		m_axis_tdata = {6'd0, status_q, rcol_q[7:0], rcol_q[15:8],
			rcol_q[23:16], hit_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rct_pkg::ST_IDLE;
			count_q  <= '0;
			bank_q   <= 1'b0;
			outv_q   <= 1'b0;
			idx_q    <= '0;
			n_q      <= '0;
			placed_q <= 1'b0;
			sub_q    <= '0;
			hit_q    <= 1'b0;
			status_q <= 1'b0;
			rcol_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q != rct_pkg::ST_DONE && state_d == rct_pkg::ST_DONE) begin
				outv_q <= 1'b1;
			end else if (outv_q && m_axis_tready) begin
				outv_q <= 1'b0;
			end
			case (state_q)
				rct_pkg::ST_IDLE: begin
					idx_q <= '0;
					n_q <= '0;
					placed_q <= 1'b0;
					sub_q <= '0;
					hit_q <= 1'b0;
					status_q <= 1'b0;
					rcol_q <= '0;
					if (in_acc &&
						rct_pkg::opcode_t'(s_axis_tdata[1:0]) == rct_pkg::OP_CLEAR) begin
						count_q <= '0;
					end
				end
				rct_pkg::ST_COUNT_RD: begin
					if (idx_q == count_q) begin
						if (n_q + CntW'(1) > DepthC) begin
							status_q <= 1'b1;
						end else begin
							sub_q <= (count_q == '0) ? 3'd3 : 3'd0;
						end
						idx_q <= '0;
						n_q <= '0;
					end
				end
				rct_pkg::ST_COUNT_EV: begin
					idx_q <= idx_q + CntW'(1);
					n_q <= n_q + CntW'(cnt_add);
				end
				rct_pkg::ST_COPY_EV: begin
					if (emit) n_q <= n_q + CntW'(1);
					if (emit && (sub_q == 3'd1 || sub_q == 3'd3)) placed_q <= 1'b1;
					if (sub_q == 3'd3) begin
						count_q <= n_q + (emit ? CntW'(1) : CntW'(0));
						bank_q <= ~bank_q;
					end else if (sub_q == 3'd2) begin
						idx_q <= idx_q + CntW'(1);
						if (idx_q + CntW'(1) == count_q) begin
							sub_q <= 3'd3;
						end else begin
							sub_q <= 3'd0;
						end
					end else begin
						sub_q <= sub_q + 3'd1;
					end
				end
				rct_pkg::ST_LOOK_EV: begin
					idx_q <= idx_q + CntW'(1);
					if (hit_e) begin
						hit_q <= 1'b1;
						rcol_q <= rd.color;
					end
				end
				default: ;
			endcase
		end
	end

	// Input payload registers, no reset needed.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			lo_q  <= s_axis_tdata[17:2];
			hi_q  <= s_axis_tdata[33:18];
			col_q <= {s_axis_tdata[41:34], s_axis_tdata[49:42], s_axis_tdata[57:50]};
			id_q  <= s_axis_tdata[73:58];
		end
	end
endmodule
`default_nettype wire

// ----- tb/sv/range_color_table_checker.sv -----
// Checker for the range color table: predicts each result beat and compares it.
`timescale 1ns / 1ps
module range_color_table_checker #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [79:0] in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] out_data,
	output int          fail_count,
	output int          pending_count
);
	typedef struct packed {
		logic       hit;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       status;
	} color_result_t;

	logic [15:0] tbl_lo [TABLE_DEPTH];
	logic [15:0] tbl_hi [TABLE_DEPTH];
	logic [23:0] tbl_color [TABLE_DEPTH];
	int tbl_count;
	color_result_t expected_colors [$];

	// Insert with the new range winning overlaps; returns 1 when the merge overflows.
	function automatic logic merge_range(logic [15:0] lo, logic [15:0] hi, logic [23:0] color);
		logic [15:0] nlo [$];
		logic [15:0] nhi [$];
		logic [23:0] ncol [$];
		logic placed;
		placed = 0;
		if (lo > hi) return 0;
		for (int i = 0; i < tbl_count; i++) begin
			if (tbl_hi[i] < lo) begin
				nlo.push_back(tbl_lo[i]); nhi.push_back(tbl_hi[i]); ncol.push_back(tbl_color[i]);
			end else if (tbl_lo[i] > hi) begin
				if (!placed) begin
					nlo.push_back(lo); nhi.push_back(hi); ncol.push_back(color);
					placed = 1;
				end
				nlo.push_back(tbl_lo[i]); nhi.push_back(tbl_hi[i]); ncol.push_back(tbl_color[i]);
			end else begin
				if (tbl_lo[i] < lo) begin
					nlo.push_back(tbl_lo[i]); nhi.push_back(lo - 16'd1);
					ncol.push_back(tbl_color[i]);
				end
				if (!placed) begin
					nlo.push_back(lo); nhi.push_back(hi); ncol.push_back(color);
					placed = 1;
				end
				if (tbl_hi[i] > hi) begin
					nlo.push_back(hi + 16'd1); nhi.push_back(tbl_hi[i]);
					ncol.push_back(tbl_color[i]);
				end
			end
		end
		if (!placed) begin
			nlo.push_back(lo); nhi.push_back(hi); ncol.push_back(color);
		end
		if (nlo.size() > TABLE_DEPTH) return 1;
		for (int i = 0; i < nlo.size(); i++) begin
			tbl_lo[i] = nlo[i]; tbl_hi[i] = nhi[i]; tbl_color[i] = ncol[i];
		end
		tbl_count = nlo.size();
		return 0;
	endfunction

	function automatic color_result_t predict_color(logic [79:0] d);
		color_result_t r;
		rct_pkg::opcode_t op;
		logic [15:0] id;
		r = '{default: 0};
		op = rct_pkg::opcode_t'(d[1:0]);
		id = d[73:58];
		case (op)
			rct_pkg::OP_INSERT: r.status = merge_range(d[17:2], d[33:18],
				{d[41:34], d[49:42], d[57:50]});
			rct_pkg::OP_LOOKUP: begin
				for (int i = 0; i < tbl_count; i++) begin
					if (id >= tbl_lo[i] && id <= tbl_hi[i]) begin
						r.hit = 1;
						{r.red, r.green, r.blue} = tbl_color[i];
						break;
					end
				end
			end
			rct_pkg::OP_CLEAR: tbl_count = 0;
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		color_result_t exp_r;
		color_result_t got;
		if (!arst_n) begin
			tbl_count = 0;
			fail_count = 0;
			expected_colors.delete();
			pending_count = 0;
		end else begin
			if (in_valid && in_ready) expected_colors.push_back(predict_color(in_data));
			if (out_valid && out_ready) begin
				got.hit = out_data[0];
				got.red = out_data[8:1];
				got.green = out_data[16:9];
				got.blue = out_data[24:17];
				got.status = out_data[25];
				if (expected_colors.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result beat %h", $time, out_data);
				end else begin
					exp_r = expected_colors.pop_front();
					if (exp_r != got) begin
						fail_count++;
						$display("%0t: mismatch expected hit=%0d rgb=%h%h%h status=%0d",
							$time, exp_r.hit, exp_r.red, exp_r.green, exp_r.blue,
							exp_r.status);
						$display("%0t:          actual   hit=%0d rgb=%h%h%h status=%0d",
							$time, got.hit, got.red, got.green, got.blue, got.status);
					end
				end
			end
			pending_count = expected_colors.size();
		end
	end
endmodule

// ----- tb/sv/range_color_table_top_test.sv -----
// Testbench top for the range color table: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module range_color_table_top_test;
	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [31:0] m_axis_tdata;
	int          fail_count;
	int          pending_count;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	logic        hold_off = 0;

	always #10 clk = ~clk;

	range_color_table_top dut (.*);

	range_color_table_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	// Receiver: random stalls, or a long hold-off when asked.
	always @(negedge clk) begin
		m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	// Valid stays high after a beat is taken until the next call decides to idle,
	// so back-to-back beats need only one update per edge.
	task automatic send_beat(rct_pkg::opcode_t op, logic [15:0] lo, logic [15:0] hi,
			logic [23:0] color, logic [15:0] id);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 0;
			@(negedge clk);
		end
		s_axis_tdata <= {6'd0, id, color[7:0], color[15:8], color[23:16], hi, lo, op};
		s_axis_tvalid <= 1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random(int span);
		logic [15:0] lo;
		logic [15:0] w;
		int pick;
		pick = $urandom_range(99);
		lo = (span == 0) ? 16'($urandom) : 16'($urandom_range(span));
		w = 16'($urandom_range(span == 0 ? 4000 : span / 8));
		if (pick < 45)
			send_beat(rct_pkg::OP_INSERT, lo, (lo > 16'hFFFF - w) ? 16'hFFFF : lo + w,
				24'($urandom), 16'($urandom));
		else if (pick < 88)
			send_beat(rct_pkg::OP_LOOKUP, 16'($urandom), 16'($urandom), 24'($urandom),
				(span == 0) ? 16'($urandom) : 16'($urandom_range(span)));
		else if (pick < 91)
			send_beat(rct_pkg::OP_CLEAR, 16'($urandom), 16'($urandom), 24'($urandom),
				16'($urandom));
		else if (pick < 94)
			send_beat(rct_pkg::OP_NONE, 16'($urandom), 16'($urandom), 24'($urandom),
				16'($urandom));
		else
			send_beat(rct_pkg::OP_INSERT, 16'($urandom), 16'($urandom), 24'($urandom),
				16'($urandom));
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// Directed: extremes, prefix/suffix/shared-endpoint overlaps, split, miss, invalid range, no-op, clear.
		send_beat(rct_pkg::OP_LOOKUP, 0, 0, 0, 16'h0000);
		send_beat(rct_pkg::OP_INSERT, 16'h0000, 16'hFFFF, 24'hFFFFFF, 0);
		send_beat(rct_pkg::OP_LOOKUP, 0, 0, 0, 16'hFFFF);
		send_beat(rct_pkg::OP_INSERT, 16'h1000, 16'h1FFF, 24'h123456, 0);
		send_beat(rct_pkg::OP_LOOKUP, 0, 0, 0, 16'h0FFF);
		send_beat(rct_pkg::OP_LOOKUP, 0, 0, 0, 16'h2000);
		send_beat(rct_pkg::OP_INSERT, 16'h1000, 16'h10FF, 24'hA5A5A5, 0);
		send_beat(rct_pkg::OP_LOOKUP, 0, 0, 0, 16'h1100);
		send_beat(rct_pkg::OP_INSERT, 16'h1FFF, 16'h2000, 24'h5A5A5A, 0);
		send_beat(rct_pkg::OP_LOOKUP, 0, 0, 0, 16'h1FFE);
		send_beat(rct_pkg::OP_INSERT, 16'h3000, 16'h2FFF, 24'h010203, 0);
		send_beat(rct_pkg::OP_INSERT, 16'hFFFF, 16'hFFFF, 24'h000000, 0);
		send_beat(rct_pkg::OP_LOOKUP, 0, 0, 0, 16'hFFFF);
		send_beat(rct_pkg::OP_NONE, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 16'hFFFF);
		send_beat(rct_pkg::OP_CLEAR, 0, 0, 0, 0);
		send_beat(rct_pkg::OP_LOOKUP, 0, 0, 0, 16'h1000);
		// Fill past capacity with disjoint single ids to hit overflow.
		for (int i = 0; i < 66; i++)
			send_beat(rct_pkg::OP_INSERT, 16'(i * 4), 16'(i * 4), 24'(i * 24'h030507), 0);
		send_beat(rct_pkg::OP_LOOKUP, 0, 0, 0, 16'd252);
		send_beat(rct_pkg::OP_INSERT, 16'd1, 16'd1, 24'h777777, 0);
		send_beat(rct_pkg::OP_CLEAR, 0, 0, 0, 0);
		// Random phases: free-running, idle sender, stalling receiver, both.
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 8 : 76) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 8 : 76) : 0;
			for (int k = 0; k < 80; k++) send_random(ph[0] ? 0 : 1023);
		end
		s_axis_tvalid <= 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		while (pending_count != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Long receiver hold-off while the sender keeps offering beats.
	initial begin
		wait (arst_n);
		repeat (3000) @(negedge clk);
		hold_off <= 1;
		repeat (2000) @(negedge clk);
		hold_off <= 0;
	end

	initial begin
		#40ms;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
